// ===== design/cps_pkg.sv =====
// cps_pkg: widths, state encoding and the source clock table for the
// countdown period selector; no dependencies
`timescale 1ns / 1ps

package cps_pkg;

  localparam int REQ_W    = 32;
  localparam int CNT_W    = 16;
  localparam int CODE_W   = 3;
  localparam int MINC_W   = 16;
  localparam int ESH_W    = 5;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int PER_W    = 32;
  localparam int MAX_SH   = 12;              // log2 of the largest divider
  localparam int NUM_W    = REQ_W + MAX_SH;  // request times divider
  localparam int Q_W      = NUM_W + 1;       // quotient after rounding up
  localparam int UNIT_W   = 22;              // widest period numerator
  localparam int SH_W     = 4;
  localparam int PROD_W   = CNT_W + UNIT_W;
  localparam int BITCNT_W = $clog2(NUM_W);

  localparam int NUM_CLOCKS = 5;
  localparam int IDX_W      = $clog2(NUM_CLOCKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CLOCKS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_LEAST_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_SHIFT = 1'b1;

  localparam logic [MINC_W-1:0] LEAST_COUNT_RST = 16'd16;
  localparam logic [ESH_W-1:0]  ERROR_SHIFT_RST = 5'd8;

  // clocks in the order they are tried: 64 Hz, 1 Hz, 1/60 Hz, 1/3600 Hz, 4096 Hz
  localparam logic [UNIT_W-1:0] CLK_UNIT [NUM_CLOCKS] = '{
    22'd1000, 22'd1000, 22'd60000, 22'd3600000, 22'd1000
  };
  localparam logic [SH_W-1:0] CLK_SHIFT [NUM_CLOCKS] = '{
    4'd6, 4'd0, 4'd0, 4'd0, 4'd12
  };
  localparam logic [REQ_W-1:0] CLK_RANGE [NUM_CLOCKS] = '{
    32'd1023984, 32'd65535000, 32'd3932100000, 32'hFFFF_FFFF, 32'd15999
  };
  localparam logic [CNT_W-1:0] CLK_LIMIT [NUM_CLOCKS] = '{
    16'd65535, 16'd65535, 16'd65535, 16'd1193, 16'd65535
  };
  // limit times numerator, the value a clamped count stands for
  localparam logic [NUM_W-1:0] CLK_LIMPROD [NUM_CLOCKS] = '{
    44'd65535000, 44'd65535000, 44'd3932100000, 44'd4294800000, 44'd65535000
  };
  localparam logic [CODE_W-1:0] CLK_CODE [NUM_CLOCKS] = '{
    3'd1, 3'd2, 3'd3, 3'd4, 3'd0
  };

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RANGE = 9'b000000010,
    ST_DIV   = 9'b000000100,
    ST_ROUND = 9'b000001000,
    ST_CLAMP = 9'b000010000,
    ST_CHECK = 9'b000100000,
    ST_MULT  = 9'b001000000,
    ST_FINAL = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

endpackage

// ===== design/countdown_period_selector.sv =====
// countdown_period_selector: picks a source clock and countdown preset for a
// requested period with one shared restoring divider; depends on cps_pkg
`timescale 1ns / 1ps
// sequence: a stop request goes straight to the result; each clock tried runs a range
// check, the divider over all 44 quotient bits, round, clamp and the accept test, a
// skipped clock only the range check; the period is then formed in the mult and final states
// throughput: one transfer at a time, set by the bit-serial divider loop
// reset: least count 16, error_shift 8, block idle, no result pending
module countdown_period_selector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [cps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cps_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cps_pkg::REQ_W-1:0]         request_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              running,
  output logic [cps_pkg::CODE_W-1:0]        clock_code,
  output logic [cps_pkg::CNT_W-1:0]         count,
  output logic [cps_pkg::PER_W-1:0]         period_ms
);
  import cps_pkg::*;

  state_t               state;
  logic [MINC_W-1:0]    least_count;
  logic [ESH_W-1:0]     error_shift;
  logic [REQ_W-1:0]     req;
  logic [IDX_W-1:0]     clk_idx;
  logic                 skipped;
  logic [NUM_W-1:0]     num;
  logic [NUM_W-1:0]     dvd;
  logic [UNIT_W-1:0]    rem;
  logic [BITCNT_W-1:0]  bit_cnt;
  logic [Q_W-1:0]       q;
  logic [NUM_W-1:0]     err;
  logic [PROD_W-1:0]    prod;
  logic                 res_running;
  logic [CODE_W-1:0]    res_code;
  logic [CNT_W-1:0]     res_count;
  logic [PER_W-1:0]     res_period;

  logic [UNIT_W-1:0]    unit;
  logic [UNIT_W:0]      trial;
  logic                 trial_ge;
  logic                 round_up;
  logic                 accept;
  logic [PROD_W-1:0]    half;
  logic [PROD_W-1:0]    per_full;
  logic                 out_free;

  assign unit     = CLK_UNIT[clk_idx];
  assign trial    = {rem, dvd[NUM_W-1]};
  assign trial_ge = trial >= {1'b0, unit};
  assign round_up = skipped ? (rem != '0) : ({rem, 1'b0} >= {1'b0, unit});
  assign accept   = (clk_idx == LAST_IDX) ||
                    ((q >= Q_W'(least_count)) && (err <= (num >> error_shift)));
  // half the divider, zero when the divider is one
  assign half     = (PROD_W'(1) << CLK_SHIFT[clk_idx]) >> 1;
  assign per_full = (prod + half) >> CLK_SHIFT[clk_idx];
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      least_count <= LEAST_COUNT_RST;
      error_shift <= ERROR_SHIFT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LEAST_COUNT: least_count <= cfg_data[MINC_W-1:0];
        REG_ERROR_SHIFT: error_shift <= cfg_data[ESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a result is offered from the done state until its transfer
      if (state == ST_DONE) out_valid <= 1'b1;
      else if (!out_stall)  out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req     <= request_ms;
            clk_idx <= '0;
            skipped <= 1'b0;
            if (request_ms == '0) begin
              res_running <= 1'b0;
              res_code    <= '0;
              res_count   <= '0;
              res_period  <= '0;
              state       <= ST_DONE;
            end else begin
              state <= ST_RANGE;
            end
          end
        end
        ST_RANGE: begin
          if (req > CLK_RANGE[clk_idx]) begin
            skipped <= 1'b1;
            if (clk_idx == LAST_IDX) begin
              // nothing accepted, report stopped
              res_running <= 1'b0;
              res_code    <= '0;
              res_count   <= '0;
              res_period  <= '0;
              state       <= ST_DONE;
            end else begin
              clk_idx <= clk_idx + 1'b1;
            end
          end else begin
            num     <= NUM_W'(req) << CLK_SHIFT[clk_idx];
            dvd     <= NUM_W'(req) << CLK_SHIFT[clk_idx];
            rem     <= '0;
            bit_cnt <= BITCNT_W'(NUM_W - 1);
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          // one quotient bit a cycle, quotient shifts in behind the dividend
          if (trial_ge) rem <= trial[UNIT_W-1:0] - unit;
          else          rem <= trial[UNIT_W-1:0];
          dvd <= {dvd[NUM_W-2:0], trial_ge};
          if (bit_cnt == '0) state <= ST_ROUND;
          else               bit_cnt <= bit_cnt - 1'b1;
        end
        ST_ROUND: begin
          if (round_up) begin
            q   <= Q_W'(dvd) + 1'b1;
            err <= NUM_W'(unit - rem);
          end else begin
            q   <= Q_W'(dvd);
            err <= NUM_W'(rem);
          end
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          if (q > Q_W'(CLK_LIMIT[clk_idx])) begin
            q   <= Q_W'(CLK_LIMIT[clk_idx]);
            err <= num - CLK_LIMPROD[clk_idx];
          end
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (accept) begin
            state <= ST_MULT;
          end else begin
            clk_idx <= clk_idx + 1'b1;
            state   <= ST_RANGE;
          end
        end
        ST_MULT: begin
          prod  <= q[CNT_W-1:0] * unit;
          state <= ST_FINAL;
        end
        ST_FINAL: begin
          if (q[CNT_W-1:0] == '0) begin
            // a zero preset cannot run
            res_running <= 1'b0;
            res_code    <= '0;
            res_count   <= '0;
            res_period  <= '0;
          end else begin
            res_running <= 1'b1;
            res_code    <= CLK_CODE[clk_idx];
            res_count   <= q[CNT_W-1:0];
            res_period  <= (per_full == '0) ? PER_W'(1) : per_full[PER_W-1:0];
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            running    <= res_running;
            clock_code <= res_code;
            count      <= res_count;
            period_ms  <= res_period;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/cps_checker.sv =====
// cps_checker: port-level checks for countdown_period_selector, bound to the
// top level below; depends on cps_pkg
`timescale 1ns / 1ps

module cps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          running,
  input logic [cps_pkg::CODE_W-1:0]    clock_code,
  input logic [cps_pkg::CNT_W-1:0]     count,
  input logic [cps_pkg::PER_W-1:0]     period_ms
);
  import cps_pkg::*;

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // an accepted request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a transfer");

  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !running |-> clock_code == '0 && count == '0 && period_ms == '0)
    else $error("stopped result with nonzero fields");

  a_running_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && running |-> count != '0 && period_ms != '0 &&
                             clock_code <= CODE_W'(NUM_CLOCKS - 1))
    else $error("running result with zero count, zero period or bad code");

endmodule

bind countdown_period_selector cps_checker u_cps_checker (.*);

// ===== dv/countdown_period_selector_tb.sv =====
// countdown_period_selector_tb: self-checking regression for the countdown period
// selector; predicts the chosen source clock, preset and period for every request
// and checks each result transfer in order; depends on cps_pkg and the block
`timescale 1ns / 1ps

module countdown_period_selector_tb;
  import cps_pkg::*;

  localparam int NUM_SRC = 5;
  localparam int LONG_HOLD = 500;
  localparam int SETTLE_CYCLES = 300;

  localparam logic [CODE_W-1:0] CODE_4096HZ = 3'd0;
  localparam logic [CODE_W-1:0] CODE_64HZ   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_1HZ    = 3'd2;
  localparam logic [CODE_W-1:0] CODE_MINUTE = 3'd3;
  localparam logic [CODE_W-1:0] CODE_HOUR   = 3'd4;

  // sources in the order they are tried; period of one tick is unit / div ms
  localparam bit [63:0] SRC_UNIT [NUM_SRC] = '{64'd1000, 64'd1000, 64'd60000,
                                               64'd3600000, 64'd1000};
  localparam bit [63:0] SRC_DIV [NUM_SRC] = '{64'd64, 64'd1, 64'd1, 64'd1, 64'd4096};
  localparam bit [63:0] SRC_RANGE [NUM_SRC] = '{64'd1023984, 64'd65535000,
                                                64'd3932100000, 64'hFFFF_FFFF, 64'd15999};
  localparam bit [63:0] SRC_LIMIT [NUM_SRC] = '{64'd65535, 64'd65535, 64'd65535,
                                                64'd1193, 64'd65535};
  localparam logic [CODE_W-1:0] SRC_CODE [NUM_SRC] = '{CODE_64HZ, CODE_1HZ, CODE_MINUTE,
                                                       CODE_HOUR, CODE_4096HZ};

  typedef struct {
    logic [REQ_W-1:0]  request;
    logic              running;
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  preset;
    logic [PER_W-1:0]  period;
  } period_choice_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [REQ_W-1:0]  request_ms = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              running;
  logic [CODE_W-1:0] clock_code;
  logic [CNT_W-1:0]  count;
  logic [PER_W-1:0]  period_ms;

  logic [MINC_W-1:0] least_count = 16'd16;
  logic [ESH_W-1:0]  tolerance_shift = 5'd8;

  period_choice_t awaited_choices [$];
  int unsigned    faults = 0;
  bit             quiet_run = 1'b0;
  bit             long_hold_pending = 1'b0;

  countdown_period_selector u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .request_ms (request_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .running    (running),
    .clock_code (clock_code),
    .count      (count),
    .period_ms  (period_ms)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic period_choice_t choose_period(input logic [REQ_W-1:0] req);
    period_choice_t c;
    bit [63:0] num, q, rem, preset, per;
    bit round_up, found;
    int pick;
    c.request = req;
    c.running = 1'b0;
    c.code = '0;
    c.preset = '0;
    c.period = '0;
    round_up = 1'b0;
    found = 1'b0;
    pick = 0;
    preset = 0;
    if (req == '0) return c;
    for (int i = 0; i < NUM_SRC; i++) begin
      if (found) continue;
      // once a finer source is out of range every later count rounds up
      if (64'(req) > SRC_RANGE[i]) begin
        round_up = 1'b1;
        continue;
      end
      num = 64'(req) * SRC_DIV[i];
      q = num / SRC_UNIT[i];
      rem = num % SRC_UNIT[i];
      if (round_up ? (rem != 0) : (rem * 2 >= SRC_UNIT[i])) begin
        q = q + 1;
        rem = SRC_UNIT[i] - rem;
      end
      if (q > SRC_LIMIT[i]) begin
        q = SRC_LIMIT[i];
        rem = num - q * SRC_UNIT[i];
      end
      if (i == NUM_SRC - 1 || (q >= 64'(least_count) && (rem << tolerance_shift) <= num)) begin
        found = 1'b1;
        pick = i;
        preset = q;
      end
    end
    // a zero preset cannot run, so it reads as stopped
    if (found && preset != 0) begin
      per = (preset * SRC_UNIT[pick] + (SRC_DIV[pick] >> 1)) / SRC_DIV[pick];
      if (per == 0) per = 1;
      c.running = 1'b1;
      c.code = SRC_CODE[pick];
      c.preset = preset[CNT_W-1:0];
      c.period = per[PER_W-1:0];
    end
    return c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  function automatic logic [REQ_W-1:0] pick_request();
    logic [REQ_W-1:0] r;
    logic [REQ_W-1:0] edges [5];
    edges = '{32'd15999, 32'd1023984, 32'd65535000, 32'd3932100000, 32'd4294800000};
    case ($urandom_range(0, 9))
      0: r = $urandom_range(0, 40);
      1: r = $urandom_range(1, 15999);
      2: r = $urandom_range(16000, 1023984);
      3: r = $urandom_range(1023985, 65535000);
      4: r = $urandom_range(65535001, 32'd3932100000);
      5: r = $urandom_range(32'd3932100001, 32'hFFFF_FFFF);
      6: r = $urandom;
      7: r = edges[$urandom_range(0, 4)] + $urandom_range(0, 6) - 32'd3;
      // whole numbers of ticks, where the error is exactly zero
      8: begin
        case ($urandom_range(0, 2))
          0: r = 32'($urandom_range(1, 8191)) * 32'd125;
          1: r = 32'($urandom_range(1, 65535)) * 32'd1000;
          default: r = 32'($urandom_range(1, 65535)) * 32'd60000;
        endcase
      end
      default: r = 32'($urandom_range(1, 1193)) * 32'd3600000;
    endcase
    return r;
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] req);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      request_ms <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    request_ms <= req;
    do @(posedge clk); while (in_stall);
    awaited_choices.push_back(choose_period(req));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_choices.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_index <= CFG_IDX_W'($urandom);
    cfg_data <= CFG_W'($urandom);
    if (idx == REG_LEAST_COUNT) least_count = data[MINC_W-1:0];
    else tolerance_shift = data[ESH_W-1:0];
  endtask

  task automatic apply_settings(input logic [MINC_W-1:0] min_cnt, input logic [ESH_W-1:0] sh);
    logic [CFG_W-1:0] d;
    d = CFG_W'($urandom);
    // upper bits of the shift write carry noise, only the low field counts
    d[ESH_W-1:0] = sh;
    write_reg(REG_LEAST_COUNT, CFG_W'(min_cnt));
    write_reg(REG_ERROR_SHIFT, d);
  endtask

  task automatic test_reset_values();
    logic [REQ_W-1:0] reqs [15];
    reqs = '{32'd0, 32'd1, 32'd8, 32'd15999, 32'd16000, 32'd1023984, 32'd1023985,
             32'd65535000, 32'd65535001, 32'd3932100000, 32'd3932100001,
             32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'd3600000};
    foreach (reqs[i]) send_request(reqs[i]);
    wait_for_results();
  endtask

  task automatic test_zero_preset();
    logic [REQ_W-1:0] reqs [5];
    reqs = '{32'd1, 32'd5, 32'd7, 32'd8, 32'd1000};
    apply_settings(16'd0, 5'd0);
    foreach (reqs[i]) send_request(reqs[i]);
    wait_for_results();
  endtask

  task automatic test_no_source();
    // past the 4096 Hz range with every coarser source refused
    apply_settings(16'd2000, 5'd8);
    send_request(32'd20000);
    send_request(32'd3932100001);
    send_request(32'hFFFF_FFFF);
    wait_for_results();
    apply_settings(16'd1, 5'd31);
    send_request(32'hFFFF_FFFF);
    send_request(32'd3932100007);
    wait_for_results();
  endtask

  task automatic test_setting_sweep();
    logic [MINC_W-1:0] mins [8];
    logic [ESH_W-1:0]  shifts [8];
    mins = '{16'd1, 16'd65535, 16'd1, 16'd65535, 16'd200, 16'd16, 16'd0, 16'd0};
    shifts = '{5'd0, 5'd16, 5'd31, 5'd0, 5'd4, 5'd20, 5'd12, 5'd0};
    mins[7] = MINC_W'($urandom);
    shifts[7] = ESH_W'($urandom_range(0, 16));
    foreach (mins[i]) begin
      apply_settings(mins[i], shifts[i]);
      repeat (30) send_request(pick_request());
      wait_for_results();
    end
  endtask

  task automatic test_back_to_back();
    apply_settings(16'd16, 5'd8);
    quiet_run = 1'b1;
    repeat (30) send_request(pick_request());
    wait_for_results();
    quiet_run = 1'b0;
  endtask

  task automatic test_output_hold();
    // receiver holds off while requests keep coming, so the input backs up
    long_hold_pending = 1'b1;
    repeat (8) send_request(pick_request());
    wait_for_results();
  endtask

  task automatic test_random_mix();
    repeat (4) begin
      apply_settings(MINC_W'($urandom_range(1, 300)), ESH_W'($urandom_range(0, 16)));
      repeat (40) send_request(pick_request());
      wait_for_results();
    end
  endtask

  task automatic check_field(input string what, input logic [REQ_W-1:0] req,
                             input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: request %0d %s expected %0d actual %0d", $time, req, what, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin
    period_choice_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_choices.size() == 0) begin
        $display("%0t ns: result transfer with nothing awaited, expected none actual %0d/%0d/%0d/%0d",
                 $time, running, clock_code, count, period_ms);
        faults++;
      end else begin
        want = awaited_choices.pop_front();
        check_field("running", want.request, 32'(want.running), 32'(running));
        check_field("clock_code", want.request, 32'(want.code), 32'(clock_code));
        check_field("count", want.request, 32'(want.preset), 32'(count));
        check_field("period_ms", want.request, want.period, period_ms);
      end
    end
  end

  // result side: random stalls, and one long hold counted here
  initial begin
    int unsigned stall_len;
    @(negedge clk);
    forever begin
      if (long_hold_pending) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_pending = 1'b0;
      end else begin
        stall_len = pick_gap();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_zero_preset();
    test_no_source();
    test_setting_sweep();
    test_back_to_back();
    test_output_hold();
    test_random_mix();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("countdown_period_selector regression: pass");
    end else begin
      $display("countdown_period_selector regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t ns: timed out with %0d results outstanding", $time, awaited_choices.size());
    $display("countdown_period_selector regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
design/cps_pkg.sv
design/countdown_period_selector.sv
design/cps_checker.sv
dv/countdown_period_selector_tb.sv
